@@ sv/dual_slot_boot_failover_core_defines.svh @@
// assertion macros for the dual-slot boot failover core
// used by the top level only; no other dependencies
`ifndef DUAL_SLOT_BOOT_FAILOVER_CORE_DEFINES_SVH
`define DUAL_SLOT_BOOT_FAILOVER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DSBF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dsbf assertion failed");

// next-cycle implication, disabled in reset
`define DSBF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dsbf assertion failed");

`endif

@@ sv/dsbf_pkg.sv @@
// shared types, codes and helpers for the dual-slot boot failover core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dsbf_pkg;

  // saturation limit of try and switch counts
  localparam int COUNT_MAX = 7;
  localparam logic [2:0] CNT_LIM = 3'((COUNT_MAX < 7) ? COUNT_MAX : 7);
  localparam logic [1:0] RUNTIME_SAT = 2'd3;

  // item modes
  localparam logic [2:0] MODE_BOOT        = 3'd0;
  localparam logic [2:0] MODE_CLEAR_SLOT  = 3'd1;
  localparam logic [2:0] MODE_CLEAR_TRIES = 3'd2;
  localparam logic [2:0] MODE_MARK_BOOTED = 3'd3;
  localparam logic [2:0] MODE_SET_FLAG    = 3'd4;
  localparam logic [2:0] MODE_SET_TARGET  = 3'd5;

  // slot status codes
  localparam logic [1:0] ST_INIT    = 2'd0;
  localparam logic [1:0] ST_TRYBOOT = 2'd1;
  localparam logic [1:0] ST_SUCCESS = 2'd2;
  localparam logic [1:0] ST_FAILED  = 2'd3;

  // slot reference code meaning none
  localparam logic [1:0] SLOT_NONE = 2'd0;

  // config register indexes
  localparam logic REG_RUNTIME_WDT_EN = 1'b0;

  typedef struct packed {
    logic [2:0] mode;
    logic       slot;
    logic       pin_reset;
    logic       boot_wdt_reset;
    logic       runtime_wdt_reset;
    logic       inactive_auth_ok;
    logic       flag_value;
  } item_t;

  typedef struct packed {
    logic [1:0][1:0] status;
    logic [1:0][2:0] tries;
    logic [1:0][2:0] switches;
    logic [1:0][1:0] runtime;
    logic [1:0]      last_tried;
    logic [1:0]      last_booted;
    logic [1:0]      target;
  } record_t;

  typedef struct packed {
    logic       watchdog_enable;
    logic [1:0] switch_to;
  } verdict_t;

  function automatic logic [2:0] sat_inc(input logic [2:0] v);
    sat_inc = (v >= CNT_LIM) ? CNT_LIM : v + 3'd1;
  endfunction

endpackage

`default_nettype wire

@@ sv/dsbf_apb_regs.sv @@
// configuration register file on the apb-style port
// depends on dsbf_pkg
`timescale 1ns / 1ps
`default_nettype none

module dsbf_apb_regs
  import dsbf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic             runtime_wdt_enable
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // runtime watchdog enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      runtime_wdt_enable <= 1'b0;
    end else if (wr_en && paddr[2] == REG_RUNTIME_WDT_EN) begin
      runtime_wdt_enable <= pwdata[0];
    end
  end

  // read mux
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_RUNTIME_WDT_EN) begin
      prdata = {31'd0, runtime_wdt_enable};
    end
  end

endmodule

`default_nettype wire

@@ sv/dsbf_update.sv @@
// next-record and verdict logic for one item
// depends on dsbf_pkg
`timescale 1ns / 1ps
`default_nettype none

module dsbf_update
  import dsbf_pkg::*;
(
  input  wire record_t cur,
  input  wire item_t   item,
  input  wire logic    runtime_wdt_enable,
  output record_t      nxt,
  output verdict_t     verdict
);

  record_t r;
  logic    prev;
  logic    other;
  logic    cur_failed;
  logic    other_failed;
  logic    wd;
  logic [1:0] sw;

  always_comb begin
    r            = cur;
    wd           = 1'b0;
    sw           = SLOT_NONE;
    other        = ~item.slot;
    prev         = (cur.last_tried == 2'd1) ? 1'b0 : 1'b1;
    cur_failed   = 1'b0;
    other_failed = 1'b0;
    case (item.mode)
      MODE_BOOT: begin
        // pin reset wipes the record
        if (item.pin_reset) begin
          r = '0;
        end
        prev = (r.last_tried == 2'd1) ? 1'b0 : 1'b1;
        // reset causes against the slot tried last
        for (int i = 0; i < 2; i++) begin
          if (r.last_tried != SLOT_NONE && prev == 1'(i)) begin
            if (item.boot_wdt_reset) begin
              r.status[i] = ST_FAILED;
            end
            if (runtime_wdt_enable && item.runtime_wdt_reset &&
                r.runtime[i] != RUNTIME_SAT) begin
              r.runtime[i] = r.runtime[i] + 2'd1;
            end
          end
        end
        // failure flags of booting and inactive slot
        for (int i = 0; i < 2; i++) begin
          if (item.slot == 1'(i)) begin
            cur_failed = (r.status[i] == ST_FAILED);
          end else begin
            other_failed = (r.status[i] == ST_FAILED);
          end
        end
        // count the attempt
        for (int i = 0; i < 2; i++) begin
          if (item.slot == 1'(i) && !cur_failed) begin
            r.tries[i] = sat_inc(r.tries[i]);
          end
        end
        r.last_tried = {1'b0, item.slot} + 2'd1;
        wd = item.inactive_auth_ok & ~cur_failed;
        // failover onto a healthy inactive slot
        if (item.inactive_auth_ok && cur_failed && !other_failed) begin
          for (int i = 0; i < 2; i++) begin
            if (other == 1'(i)) begin
              r.status[i]   = ST_TRYBOOT;
              r.switches[i] = sat_inc(r.switches[i]);
            end
          end
          r.last_tried = {1'b0, other} + 2'd1;
          sw           = {1'b0, other} + 2'd1;
        end
      end
      MODE_CLEAR_SLOT: begin
        for (int i = 0; i < 2; i++) begin
          if (item.slot == 1'(i)) begin
            r.status[i]   = ST_SUCCESS;
            r.tries[i]    = 3'd0;
            r.switches[i] = 3'd0;
          end
        end
      end
      MODE_CLEAR_TRIES: begin
        for (int i = 0; i < 2; i++) begin
          if (item.slot == 1'(i)) begin
            r.tries[i] = 3'd0;
          end
        end
      end
      MODE_MARK_BOOTED: begin
        r.last_booted = {1'b0, item.slot} + 2'd1;
      end
      MODE_SET_FLAG: begin
        for (int i = 0; i < 2; i++) begin
          if (item.slot == 1'(i)) begin
            r.runtime[i] = {1'b0, item.flag_value};
          end
        end
      end
      MODE_SET_TARGET: begin
        r.target = {1'b0, item.slot} + 2'd1;
      end
      default: begin
        // query and unused mode leave the record as is
      end
    endcase
  end

  assign nxt                     = r;
  assign verdict.watchdog_enable = wd;
  assign verdict.switch_to       = sw;

endmodule

`default_nettype wire

@@ sv/dual_slot_boot_failover_core.sv @@
// Dual-slot boot failover core: a beat passes the input register, then the record update
// into the result register. Throughput is one beat per cycle unless m_tready holds it off;
// the record read-modify-write is combinational in dsbf_update and lands in the boot record.
// Reset (rst, synchronous, active high) clears the boot record, the config register
// and both stage valid flags; payload registers are not reset.
// depends on dsbf_pkg, dsbf_apb_regs, dsbf_update and the defines header
`timescale 1ns / 1ps
`default_nettype none

`include "dual_slot_boot_failover_core_defines.svh"

module dual_slot_boot_failover_core
  import dsbf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata: slot, pin_reset, boot_wdt_reset, runtime_wdt_reset,
  //          inactive_auth_ok, flag_value, 2 bits zero
  input  wire logic [7:0]  s_tdata,
  // s_tuser: mode
  input  wire logic [2:0]  s_tuser,
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata: watchdog_enable, switch_to, slot0_status, slot1_status,
  //          slot0_tries, slot1_tries, slot0_switches, slot1_switches,
  //          slot0_runtime_count, slot1_runtime_count, target_out,
  //          last_booted_out, 5 bits zero
  output logic [31:0]      m_tdata,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic     runtime_wdt_enable;
  logic     in_valid;
  item_t    in_item;
  logic     advance;
  record_t  rec;
  record_t  rec_next;
  verdict_t verdict_next;
  verdict_t out_verdict;
  record_t  out_rec;

  dsbf_apb_regs u_regs (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .runtime_wdt_enable (runtime_wdt_enable)
  );

  // stage handshakes
  assign advance  = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.mode              <= s_tuser;
      in_item.slot              <= s_tdata[0];
      in_item.pin_reset         <= s_tdata[1];
      in_item.boot_wdt_reset    <= s_tdata[2];
      in_item.runtime_wdt_reset <= s_tdata[3];
      in_item.inactive_auth_ok  <= s_tdata[4];
      in_item.flag_value        <= s_tdata[5];
    end
  end

  dsbf_update u_update (
    .cur                (rec),
    .item               (in_item),
    .runtime_wdt_enable (runtime_wdt_enable),
    .nxt                (rec_next),
    .verdict            (verdict_next)
  );

  // boot record
  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= '0;
    end else if (advance) begin
      rec <= rec_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_verdict <= verdict_next;
      out_rec     <= rec_next;
    end
  end

  // result beat packing
  assign m_tdata = {5'd0,
                    out_rec.last_booted, out_rec.target,
                    out_rec.runtime[1], out_rec.runtime[0],
                    out_rec.switches[1], out_rec.switches[0],
                    out_rec.tries[1], out_rec.tries[0],
                    out_rec.status[1], out_rec.status[0],
                    out_verdict.switch_to, out_verdict.watchdog_enable};

  // checks
  `DSBF_ASSERT_NOW(a_no_wd_with_switch, clk, rst, m_tvalid,
                   !(m_tdata[0] && m_tdata[2:1] != 2'd0))
  `DSBF_ASSERT_NOW(a_switch_code_valid, clk, rst, m_tvalid, m_tdata[2:1] != 2'd3)
  `DSBF_ASSERT_NEXT(a_input_held, clk, rst, in_valid && !advance, in_valid)
  `DSBF_ASSERT_NEXT(a_advance_gives_result, clk, rst, advance, m_tvalid)

endmodule

`default_nettype wire

@@ dv/dual_slot_boot_failover_core_test.sv @@
// self-checking testbench for the dual-slot boot failover core
// depends on dsbf_pkg and dual_slot_boot_failover_core; stream beats are checked
// against an in-bench model of the boot record
`timescale 1ns / 1ps

module dual_slot_boot_failover_core_test;
  import dsbf_pkg::*;

  // modes the package leaves unnamed
  localparam logic [2:0] MODE_QUERY  = 3'd6;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  // slot references as held in the record
  localparam logic [1:0] REF_SLOT0 = 2'd1;
  localparam logic [1:0] REF_SLOT1 = 2'd2;

  localparam logic [2:0] WDT_EN_ADDR = 3'({REG_RUNTIME_WDT_EN, 2'b00});
  localparam int         HOLD_BEAT   = 40;
  localparam int         HOLD_CYCLES = 80;
  localparam int         PHASE_ITEMS = 125;

  // result beat layout, msb first
  typedef struct packed {
    logic [4:0] pad;
    logic [1:0] last_booted;
    logic [1:0] target;
    logic [1:0] runtime1;
    logic [1:0] runtime0;
    logic [2:0] switches1;
    logic [2:0] switches0;
    logic [2:0] tries1;
    logic [2:0] tries0;
    logic [1:0] status1;
    logic [1:0] status0;
    logic [1:0] switch_to;
    logic       wd_en;
  } status_word_t;

  typedef struct {
    item_t        it;
    bit           has_gold;
    status_word_t gold;
    bit           has_cfg;
    logic         cfg_val;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // model state and bookkeeping
  record_t      boot_rec = '0;
  logic         wdt_en_shadow = 1'b0;
  status_word_t record_q[$];
  stim_row_t    directed_rows[$];
  bit           no_idle = 1'b0;
  int           err_count = 0;
  int           items_sent = 0;
  int           beats_checked = 0;
  int           boot_events = 0;
  int           switch_beats = 0;

  dual_slot_boot_failover_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // saturating bump of a try or switch count
  function automatic logic [2:0] bump_count(input logic [2:0] v);
    logic [2:0] n;
    n = v;
    if (n < CNT_LIM) n = n + 3'd1;
    return n;
  endfunction

  // apply one command to the boot record and return the reported record
  function automatic status_word_t advance_record(input item_t it);
    status_word_t w;
    logic         cur;
    logic         alt;
    logic         prev;
    w = '0;
    cur = it.slot;
    alt = ~it.slot;
    case (it.mode)
      MODE_BOOT: begin
        if (it.pin_reset) boot_rec = '0;
        // causes charged to the slot tried last; any value but slot 0 means slot 1
        if (boot_rec.last_tried != SLOT_NONE) begin
          prev = (boot_rec.last_tried != REF_SLOT0);
          if (it.boot_wdt_reset) boot_rec.status[prev] = ST_FAILED;
          if (wdt_en_shadow && it.runtime_wdt_reset && boot_rec.runtime[prev] < RUNTIME_SAT)
            boot_rec.runtime[prev] = boot_rec.runtime[prev] + 2'd1;
        end
        if (boot_rec.status[cur] != ST_FAILED)
          boot_rec.tries[cur] = bump_count(boot_rec.tries[cur]);
        boot_rec.last_tried = cur ? REF_SLOT1 : REF_SLOT0;
        w.wd_en = it.inactive_auth_ok;
        // failed current slot: fall over to a healthy inactive slot
        if (it.inactive_auth_ok && boot_rec.status[cur] == ST_FAILED) begin
          w.wd_en = 1'b0;
          if (boot_rec.status[alt] != ST_FAILED) begin
            boot_rec.status[alt] = ST_TRYBOOT;
            boot_rec.last_tried = alt ? REF_SLOT1 : REF_SLOT0;
            boot_rec.switches[alt] = bump_count(boot_rec.switches[alt]);
            w.switch_to = boot_rec.last_tried;
          end
        end
      end
      MODE_CLEAR_SLOT: begin
        boot_rec.status[cur] = ST_SUCCESS;
        boot_rec.tries[cur] = '0;
        boot_rec.switches[cur] = '0;
      end
      MODE_CLEAR_TRIES: boot_rec.tries[cur] = '0;
      MODE_MARK_BOOTED: boot_rec.last_booted = cur ? REF_SLOT1 : REF_SLOT0;
      MODE_SET_FLAG: boot_rec.runtime[cur] = {1'b0, it.flag_value};
      MODE_SET_TARGET: boot_rec.target = cur ? REF_SLOT1 : REF_SLOT0;
      default: ;
    endcase
    w.status0 = boot_rec.status[0];
    w.status1 = boot_rec.status[1];
    w.tries0 = boot_rec.tries[0];
    w.tries1 = boot_rec.tries[1];
    w.switches0 = boot_rec.switches[0];
    w.switches1 = boot_rec.switches[1];
    w.runtime0 = boot_rec.runtime[0];
    w.runtime1 = boot_rec.runtime[1];
    w.target = boot_rec.target;
    w.last_booted = boot_rec.last_booted;
    return w;
  endfunction

  function automatic item_t make_item(input logic [2:0] mode, input logic slot,
                                      input logic pin, input logic bwdt, input logic rwdt,
                                      input logic auth, input logic flag);
    item_t it;
    it.mode = mode;
    it.slot = slot;
    it.pin_reset = pin;
    it.boot_wdt_reset = bwdt;
    it.runtime_wdt_reset = rwdt;
    it.inactive_auth_ok = auth;
    it.flag_value = flag;
    return it;
  endfunction

  // mostly boot events with plausible causes, some plain commands, some noise
  function automatic item_t random_item();
    item_t it;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      it = item_t'(9'($urandom));
    end else begin
      it.mode = (r < 60) ? MODE_BOOT : 3'($urandom_range(1, 7));
      it.slot = 1'($urandom);
      it.pin_reset = ($urandom_range(0, 99) < 5);
      it.boot_wdt_reset = ($urandom_range(0, 99) < 30);
      it.runtime_wdt_reset = ($urandom_range(0, 99) < 35);
      it.inactive_auth_ok = ($urandom_range(0, 99) < 75);
      it.flag_value = 1'($urandom);
    end
    return it;
  endfunction

  task automatic add_row(input item_t it, input bit has_gold, input status_word_t gold,
                         input bit has_cfg, input logic cfg_val);
    stim_row_t row;
    row.it = it;
    row.has_gold = has_gold;
    row.gold = gold;
    row.has_cfg = has_cfg;
    row.cfg_val = cfg_val;
    directed_rows.push_back(row);
  endtask

  // directed table; typed results only where obvious
  task automatic load_directed_rows();
    status_word_t g;
    // queries on a fresh record report all zeros
    g = '0;
    add_row(make_item(MODE_QUERY, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1, g, 0, 1'b0);
    add_row(make_item(MODE_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1), 1, g, 0, 1'b0);
    // first boot of slot 0 with good auth
    g = '0;
    g.wd_en = 1'b1;
    g.tries0 = 3'd1;
    add_row(make_item(MODE_BOOT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0), 1, g, 0, 1'b0);
    // drive try count of slot 0 into saturation
    repeat (7)
      add_row(make_item(MODE_BOOT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0), 0, g, 0, 1'b0);
    // pin reset wipes the record before counting slot 1
    g = '0;
    g.tries1 = 3'd1;
    add_row(make_item(MODE_BOOT, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0), 1, g, 0, 1'b0);
    // slot 1 fails, fall over to slot 0
    add_row(make_item(MODE_BOOT, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0), 0, g, 0, 1'b0);
    // slot 0 fails too, nowhere to go
    add_row(make_item(MODE_BOOT, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0), 0, g, 0, 1'b0);
    // runtime watchdog cause ignored while counting is off
    add_row(make_item(MODE_BOOT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0), 0, g, 0, 1'b0);
    add_row(make_item(MODE_CLEAR_SLOT, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 0, g, 0, 1'b0);
    add_row(make_item(MODE_CLEAR_TRIES, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 0, g, 0, 1'b0);
    add_row(make_item(MODE_MARK_BOOTED, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 0, g, 0, 1'b0);
    // runtime flag written with counting off
    add_row(make_item(MODE_SET_FLAG, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1), 0, g, 0, 1'b0);
    add_row(make_item(MODE_SET_TARGET, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 0, g, 0, 1'b0);
    add_row(make_item(MODE_QUERY, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1), 0, g, 0, 1'b0);
    // counting on: runtime count saturates
    add_row(make_item(MODE_BOOT, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0), 0, g, 1, 1'b1);
    repeat (4)
      add_row(make_item(MODE_BOOT, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0), 0, g, 0, 1'b0);
    add_row(make_item(MODE_SET_FLAG, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 0, g, 0, 1'b0);
  endtask

  // offer one beat after a random gap, then predict on acceptance
  task automatic send_item(input item_t it, input bit has_gold, input status_word_t gold);
    int           gap;
    status_word_t w;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.mode;
    s_tdata <= {2'b00, it.flag_value, it.inactive_auth_ok, it.runtime_wdt_reset,
                it.boot_wdt_reset, it.pin_reset, it.slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    w = advance_record(it);
    record_q.push_back(has_gold ? gold : w);
    items_sent++;
    if (it.mode == MODE_BOOT) boot_events++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (record_q.size() != 0) @(posedge clk);
  endtask

  // apb write of the runtime watchdog enable, then read it back
  task automatic write_wdt_enable(input logic val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WDT_EN_ADDR;
    pwdata <= {31'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    wdt_en_shadow = val;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {31'b0, val}) begin
      $error("runtime_wdt_enable readback: expected %0h, got %0h", {31'b0, val}, prdata);
      err_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // input side: reset, directed table, random phases, end of run
  initial begin
    stim_row_t row;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_directed_rows();
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.has_cfg) begin
        drain_results();
        write_wdt_enable(row.cfg_val);
      end
      send_item(row.it, row.has_gold, row.gold);
    end
    // random phases alternate the enable; the third phase (p == 2) runs without gaps
    for (int p = 0; p < 4; p++) begin
      drain_results();
      write_wdt_enable(~p[0]);
      no_idle = (p == 2);
      repeat (PHASE_ITEMS) send_item(random_item(), 0, '0);
    end
    drain_results();
    repeat (20) @(posedge clk);
    $display("covered %0d commands (%0d boot events), %0d result beats checked",
             items_sent, boot_events, beats_checked);
    $display("fail-over switches reported: %0d", switch_beats);
    if (err_count == 0)
      $display("dual_slot_boot_failover_core_test: clean");
    else
      $display("dual_slot_boot_failover_core_test: errors");
    $finish;
  end

  // result side: random back-pressure, one long hold-off, field compare
  initial begin
    int           gap;
    status_word_t want;
    status_word_t got;
    while (rst) @(posedge clk);
    forever begin
      if (beats_checked == HOLD_BEAT)
        gap = HOLD_CYCLES;
      else
        gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got = status_word_t'(m_tdata);
      if (record_q.size() == 0) begin
        $error("result beat %0h with nothing outstanding", m_tdata);
        err_count++;
      end else begin
        want = record_q.pop_front();
        check_field("watchdog_enable", 32'(want.wd_en), 32'(got.wd_en));
        check_field("switch_to", 32'(want.switch_to), 32'(got.switch_to));
        check_field("slot0_status", 32'(want.status0), 32'(got.status0));
        check_field("slot1_status", 32'(want.status1), 32'(got.status1));
        check_field("slot0_tries", 32'(want.tries0), 32'(got.tries0));
        check_field("slot1_tries", 32'(want.tries1), 32'(got.tries1));
        check_field("slot0_switches", 32'(want.switches0), 32'(got.switches0));
        check_field("slot1_switches", 32'(want.switches1), 32'(got.switches1));
        check_field("slot0_runtime_count", 32'(want.runtime0), 32'(got.runtime0));
        check_field("slot1_runtime_count", 32'(want.runtime1), 32'(got.runtime1));
        check_field("target_out", 32'(want.target), 32'(got.target));
        check_field("last_booted_out", 32'(want.last_booted), 32'(got.last_booted));
        check_field("pad", 32'(want.pad), 32'(got.pad));
      end
      if (got.switch_to != SLOT_NONE) switch_beats++;
      beats_checked++;
    end
  end

  // watchdog on the whole run
  initial begin
    #2000000;
    $display("dual_slot_boot_failover_core_test: errors");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/dsbf_pkg.sv
sv/dsbf_apb_regs.sv
sv/dsbf_update.sv
sv/dual_slot_boot_failover_core.sv
dv/dual_slot_boot_failover_core_test.sv
